// ===== rtl/core/rne_pkg.sv =====
// Shared types, constants and the numeral table of the Roman numeral encoder.
package rne_pkg;

  localparam int VALUE_W    = 16;
  localparam int NUM_W      = 12;
  localparam int SYM_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int MAX_CHARS  = 15;
  localparam int CHAR_CNT_W = $clog2(MAX_CHARS + 1);
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [NUM_W-1:0] RANGE_MIN_RESET = NUM_W'(1);
  localparam logic [NUM_W-1:0] RANGE_MAX_RESET = NUM_W'(3999);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 1'b1;

  localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;

  // One job handed from the front to the back
  typedef struct packed {
    logic             empty;
    logic [NUM_W-1:0] num;
  } job_t;

  // One row of the greedy table
  typedef struct packed {
    logic [NUM_W-1:0] weight;
    logic [SYM_W-1:0] first;
    logic [SYM_W-1:0] second;
  } numeral_t;

  localparam int TABLE_LEN = 13;

  function automatic numeral_t numeral_row(input int idx);
    numeral_t row;
    case (idx)
      0:       row = '{NUM_W'(1000), "M", SYM_NONE};
      1:       row = '{NUM_W'(900),  "C", "M"};
      2:       row = '{NUM_W'(500),  "D", SYM_NONE};
      3:       row = '{NUM_W'(400),  "C", "D"};
      4:       row = '{NUM_W'(100),  "C", SYM_NONE};
      5:       row = '{NUM_W'(90),   "X", "C"};
      6:       row = '{NUM_W'(50),   "L", SYM_NONE};
      7:       row = '{NUM_W'(40),   "X", "L"};
      8:       row = '{NUM_W'(10),   "X", SYM_NONE};
      9:       row = '{NUM_W'(9),    "I", "X"};
      10:      row = '{NUM_W'(5),    "V", SYM_NONE};
      11:      row = '{NUM_W'(4),    "I", "V"};
      default: row = '{NUM_W'(1),    "I", SYM_NONE};
    endcase
    return row;
  endfunction

  // Largest table weight not above rest; rest is nonzero whenever this is used
  function automatic numeral_t numeral_pick(input logic [NUM_W-1:0] rest);
    numeral_t pick;
    numeral_t row;
    pick = numeral_row(TABLE_LEN - 1);
    for (int i = TABLE_LEN - 2; i >= 0; i--) begin
      row = numeral_row(i);
      if (rest >= row.weight) begin
        pick = row;
      end
    end
    return pick;
  endfunction

endpackage

// ===== rtl/core/rne_front.sv =====
// Front end: bound registers and classification of each incoming value.
module rne_front
  import rne_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic signed [VALUE_W-1:0] value,
  output job_t                  job
);

  logic [NUM_W-1:0]   range_min;
  logic [NUM_W-1:0]   range_max;
  logic [VALUE_W-1:0] raw;
  logic               out_of_range;

  // Hold the bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= RANGE_MIN_RESET;
      range_max <= RANGE_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_MIN: range_min <= cfg_data;
        REG_RANGE_MAX: range_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify: negative, outside the bounds, or zero gives an empty numeral
  always_comb begin
    raw          = VALUE_W'(value);
    out_of_range = raw[VALUE_W-1]
                || (raw < VALUE_W'(range_min))
                || (raw > VALUE_W'(range_max));
    job.empty    = out_of_range || (raw == '0);
    job.num      = raw[NUM_W-1:0];
  end

endmodule

// ===== rtl/core/rne_queue.sv =====
// Short job queue between front and back.
module rne_queue
  import rne_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = store[rd_ptr];

  // Write the slot at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rne_back.sv =====
// Back end: greedy numeral sequencer with a registered output stage.
module rne_back
  import rne_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  job_t             head_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] symbol,
  output logic             last,
  output logic             empty_res
);

  logic                  busy;
  logic                  pending;
  logic [SYM_W-1:0]      pending_sym;
  logic [NUM_W-1:0]      rest;
  logic [CHAR_CNT_W-1:0] n_chars;

  logic                  advance;
  numeral_t              pick;
  logic [NUM_W-1:0]      rest_sub;
  logic                  final_slot;
  logic                  first_last;
  logic                  second_last;

  assign advance     = !out_valid || out_ready;
  assign pop         = advance && !busy && head_valid;
  assign pick        = numeral_pick(rest);
  assign rest_sub    = rest - pick.weight;
  assign final_slot  = (n_chars == CHAR_CNT_W'(MAX_CHARS - 1));
  assign first_last  = final_slot || ((rest_sub == '0) && (pick.second == SYM_NONE));
  assign second_last = final_slot || (rest == '0);

  // Emit one character per transfer slot, or one empty result per rejected job
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (busy) begin
        out_valid <= 1'b1;
        empty_res <= 1'b0;
        n_chars   <= n_chars + 1'b1;
        if (pending) begin
          symbol  <= pending_sym;
          last    <= second_last;
          pending <= 1'b0;
          busy    <= !second_last;
        end else begin
          symbol      <= pick.first;
          last        <= first_last;
          rest        <= rest_sub;
          pending_sym <= pick.second;
          pending     <= (pick.second != SYM_NONE) && !first_last;
          busy        <= !first_last;
        end
      end else if (head_valid) begin
        if (head_job.empty) begin
          out_valid <= 1'b1;
          symbol    <= SYM_NONE;
          last      <= 1'b1;
          empty_res <= 1'b1;
        end else begin
          out_valid <= 1'b0;
          busy      <= 1'b1;
          pending   <= 1'b0;
          rest      <= head_job.num;
          n_chars   <= '0;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/roman_numeral_encoder.sv =====
// Top level of the Roman numeral encoder: front, job queue and back.
//
//   channel   signals                               direction
//   in        in_valid/in_ready, value              into block
//   out       out_valid/out_ready, symbol,last,     out of block
//             empty_res
//   cfg       cfg_we, cfg_index, cfg_data           into block, write only
//
// An accepted value is written into the queue at the transfer; the back end
// then needs one load step and then emits one character per cycle while out is
// not stalled (1 to 15 characters per item). A rejected
// or zero value needs no load step and gives a single empty result.
// Reset clears the bounds to 1..3999 and drops all queued work.
// A stall on out only fills the queue; in stalls when the queue is full.
module roman_numeral_encoder
  import rne_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [VALUE_W-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SYM_W-1:0]      symbol,
  output logic                  last,
  output logic                  empty_res
);

  job_t front_job;
  job_t head_job;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  rne_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (value),
    .job       (front_job)
  );

  rne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (front_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  rne_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .symbol     (symbol),
    .last       (last),
    .empty_res  (empty_res)
  );

  // An empty result is always a lone, final, blank transfer
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && (symbol == SYM_NONE))
    else $error("empty result not marked last or carries a character");

  // A character result always carries a real character
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_res |-> (symbol != SYM_NONE))
    else $error("character result with blank symbol");

  // An accepted value is queued in the following cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> q_valid)
    else $error("accepted value missing from queue");

endmodule

// ===== sim/roman_numeral_check.sv =====
// Checker for the Roman numeral encoder: predicts the characters and compares each transfer.
module roman_numeral_check
  import rne_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [VALUE_W-1:0]    value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SYM_W-1:0]      symbol,
  input  logic                  last,
  input  logic                  empty_res,
  output int                    pending,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted output character
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             empty;
  } glyph_t;

  // Greedy numeral table: weight, leading character, trailing character
  localparam int NUMERAL_ROWS = 13;
  localparam int WEIGHT [NUMERAL_ROWS] =
    '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  localparam logic [SYM_W-1:0] LEAD [NUMERAL_ROWS] =
    '{"M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"};
  localparam logic [SYM_W-1:0] TRAIL [NUMERAL_ROWS] =
    '{SYM_NONE, "M", SYM_NONE, "D", SYM_NONE, "C", SYM_NONE, "L",
      SYM_NONE, "X", SYM_NONE, "V", SYM_NONE};

  int     lo_bound;
  int     hi_bound;
  glyph_t glyphs_due [$];

  // Queue the characters one accepted value must produce
  function automatic void spell_numeral(input logic [VALUE_W-1:0] v);
    int rest;
    int n;
    rest = v;
    n = 0;
    // Negative, below or above the bounds: a single empty result
    if (v[VALUE_W-1] || rest < lo_bound || rest > hi_bound) begin
      glyphs_due.push_back('{SYM_NONE, 1'b1, 1'b1});
      return;
    end
    for (int i = 0; i < NUMERAL_ROWS; i++) begin
      while (rest >= WEIGHT[i] && n < MAX_CHARS) begin
        glyphs_due.push_back('{LEAD[i], 1'b0, 1'b0});
        n++;
        if (TRAIL[i] != SYM_NONE && n < MAX_CHARS) begin
          glyphs_due.push_back('{TRAIL[i], 1'b0, 1'b0});
          n++;
        end
        rest -= WEIGHT[i];
      end
    end
    // Zero inside the bounds spells nothing and also gives the empty result
    if (n == 0) begin
      glyphs_due.push_back('{SYM_NONE, 1'b1, 1'b1});
    end else begin
      glyphs_due[glyphs_due.size() - 1].last = 1'b1;
    end
  endfunction

  // Track the bounds, predict on input transfers, compare on output transfers
  always @(posedge clk) begin : watch
    int     errs;
    glyph_t due;
    errs = 0;
    if (rst) begin
      lo_bound = RANGE_MIN_RESET;
      hi_bound = RANGE_MAX_RESET;
      glyphs_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RANGE_MIN: lo_bound = cfg_data;
          REG_RANGE_MAX: hi_bound = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        spell_numeral(value);
      end
      if (out_valid && out_ready) begin
        if (glyphs_due.size() == 0) begin
          $error("unexpected result: symbol %h last %b empty_res %b",
                 symbol, last, empty_res);
          errs++;
        end else begin
          due = glyphs_due.pop_front();
          if (symbol !== due.symbol) begin
            $error("symbol: expected %h, got %h", due.symbol, symbol);
            errs++;
          end
          if (last !== due.last) begin
            $error("last: expected %b, got %b", due.last, last);
            errs++;
          end
          if (empty_res !== due.empty) begin
            $error("empty_res: expected %b, got %b", due.empty, empty_res);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= glyphs_due.size();
  end

endmodule

// ===== sim/roman_numeral_encoder_test.sv =====
// Testbench top for the Roman numeral encoder: stimulus, bound settings and verdict.
module roman_numeral_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rne_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DIRECTED_LEN = 20;
  localparam logic [VALUE_W-1:0] DIRECTED [DIRECTED_LEN] =
    '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd14, 16'd40, 16'd49,
      16'd90, 16'd400, 16'd900, 16'd1994, 16'd3888, 16'd3999, 16'd4000,
      16'hFFFF, 16'h8000, 16'h7FFF};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_RANGE_MIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_W-1:0]    value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SYM_W-1:0]      symbol;
  logic                  last;
  logic                  empty_res;
  logic                  steady = 1'b0;
  int                    pending;
  int                    fail_count;
  int                    stuck_cycles = 0;

  roman_numeral_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last),
    .empty_res (empty_res)
  );

  roman_numeral_check check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .symbol     (symbol),
    .last       (last),
    .empty_res  (empty_res),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the output side at random, never during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 23);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one value, with random gaps, and hold it until the transfer
  task automatic push_value(input logic [VALUE_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted character has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_bounds(input int lo, input int hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RANGE_MIN;
    cfg_data  <= CFG_DATA_W'(lo);
    @(posedge clk);
    cfg_index <= REG_RANGE_MAX;
    cfg_data  <= CFG_DATA_W'(hi);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly in-range values, then the bound edges, then anything at all
  function automatic logic [VALUE_W-1:0] pick_value(input int lo, input int hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55 && lo <= hi) return VALUE_W'($urandom_range(lo, hi));
    if (roll < 75) begin
      case ($urandom_range(0, 3))
        0:       return VALUE_W'(lo - 1);
        1:       return VALUE_W'(lo);
        2:       return VALUE_W'(hi);
        default: return VALUE_W'(hi + 1);
      endcase
    end
    if (roll < 88) return VALUE_W'($urandom_range(0, 4095));
    return VALUE_W'($urandom);
  endfunction

  // Settle, set new bounds, then send a batch of random values
  task automatic run_phase(input int lo, input int hi, input int count, input bit calm);
    drain_results();
    write_bounds(lo, hi);
    for (int i = 0; i < count; i++) begin
      steady <= calm && (i < 20);
      push_value(pick_value(lo, hi));
    end
    steady <= 1'b0;
  endtask

  initial begin : stimulus
    int lo_r;
    int hi_r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset bounds: edges, every table row, long numerals, negatives
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      push_value(DIRECTED[i]);
    end

    // Widest bounds: zero accepted, values of 4000 and up repeat M, 4096 is rejected
    drain_results();
    write_bounds(0, 4095);
    push_value(16'd0);
    push_value(16'd4095);
    push_value(16'd4000);
    push_value(16'd4096);

    run_phase(0, 4095, 25, 1'b0);
    run_phase(100, 50, 10, 1'b0);
    lo_r = $urandom_range(0, 4095);
    hi_r = $urandom_range(0, 4095);
    run_phase(lo_r, hi_r, 15, 1'b0);
    run_phase(4095, 4095, 10, 1'b0);
    run_phase(0, 0, 10, 1'b0);
    run_phase(1, 3999, 30, 1'b1);

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
